// ===== hdl/xrs_pkg.sv =====
// xrs_pkg: shared types and constants of the xorshift random source
package xrs_pkg;

  localparam int unsigned SeedW  = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned PctW   = 7;

  localparam logic [SeedW-1:0] DefaultSeed = 64'hDEAD_BEEF_CAFE_BABE;
  localparam logic [SeedW-1:0] StarMult    = 64'h2545_F491_4F6C_DD1D;
  localparam int unsigned      ShA         = 12;
  localparam int unsigned      ShB         = 25;
  localparam int unsigned      ShC         = 27;
  localparam logic [WordW-1:0] PctScale    = 32'd100;

  typedef enum logic [1:0] {
    FUNC_NEXT   = 2'd0,
    FUNC_RANGE  = 2'd1,
    FUNC_CHANCE = 2'd2,
    FUNC_RESEED = 2'd3
  } func_e;

  // handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hdl/xrs_if.sv =====
// xrs_if: request and response channel interfaces of the random source
interface xrs_req_if;
  logic                        valid;
  logic                        ready;
  xrs_pkg::func_e              func;
  logic [xrs_pkg::SeedW-1:0]   seed_value;
  logic [xrs_pkg::WordW-1:0]   range_low;
  logic [xrs_pkg::WordW-1:0]   range_high;
  logic [xrs_pkg::PctW-1:0]    percent;

  modport source (output valid, func, seed_value, range_low, range_high, percent,
                  input ready);
  modport sink   (input valid, func, seed_value, range_low, range_high, percent,
                  output ready);
endinterface

interface xrs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [xrs_pkg::WordW-1:0]   value;
  logic                        hit;

  modport source (output valid, value, hit, input ready);
  modport sink   (input valid, value, hit, output ready);
endinterface

// ===== hdl/xrs_mul.sv =====
// xrs_mul: upper word of the 64-bit star product through one shared 32x32 multiplier
module xrs_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [xrs_pkg::SeedW-1:0] x_i,
  output xrs_pkg::unit_stat_t       stat_o,
  output logic [xrs_pkg::WordW-1:0] word_o
);

  localparam logic [xrs_pkg::WordW-1:0] MultLo = xrs_pkg::StarMult[31:0];
  localparam logic [xrs_pkg::WordW-1:0] MultHi = xrs_pkg::StarMult[63:32];

  logic                        busy_q;
  logic                        done_q;
  logic [1:0]                  step_q;
  logic [xrs_pkg::SeedW-1:0]   x_q;
  logic [xrs_pkg::SeedW-1:0]   prod_q;
  logic [xrs_pkg::WordW-1:0]   acc_q;
  logic [xrs_pkg::WordW-1:0]   op_a;
  logic [xrs_pkg::WordW-1:0]   op_b;
  logic [xrs_pkg::WordW-1:0]   part;

  // low*low gives the carry half, the two cross terms add only their low halves
  always_comb begin
    unique case (step_q)
      2'd0:    begin op_a = x_q[31:0];  op_b = MultLo; end
      2'd1:    begin op_a = x_q[63:32]; op_b = MultLo; end
      2'd2:    begin op_a = x_q[31:0];  op_b = MultHi; end
      default: begin op_a = '0;         op_b = '0;     end
    endcase
    part = (step_q == 2'd1) ? prod_q[63:32] : prod_q[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      x_q    <= '0;
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        x_q    <= x_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        prod_q <= op_a * op_b;
        step_q <= step_q + 2'd1;
        if (step_q != 2'd0) begin
          acc_q <= acc_q + part;
        end
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign word_o      = acc_q;

endmodule

// ===== hdl/xrs_div.sv =====
// xrs_div: restoring remainder unit, one dividend bit per cycle
module xrs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [xrs_pkg::WordW-1:0] dividend_i,
  input  logic [xrs_pkg::WordW-1:0] divisor_i,
  output xrs_pkg::unit_stat_t       stat_o,
  output logic [xrs_pkg::WordW-1:0] rem_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [4:0]                  cnt_q;
  logic [xrs_pkg::WordW-1:0]   quo_q;
  logic [xrs_pkg::WordW-1:0]   rem_q;
  logic [xrs_pkg::WordW-1:0]   den_q;
  logic [xrs_pkg::WordW:0]     trial;
  logic [xrs_pkg::WordW:0]     diff;
  logic [xrs_pkg::WordW-1:0]   rem_d;

  always_comb begin
    trial = {rem_q, quo_q[xrs_pkg::WordW-1]};
    diff  = trial - {1'b0, den_q};
    rem_d = diff[xrs_pkg::WordW] ? trial[xrs_pkg::WordW-1:0] : diff[xrs_pkg::WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        den_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[xrs_pkg::WordW-2:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ===== hdl/xorshift_random_source.sv =====
// xorshift_random_source: xorshift64* generator with ranged and chance draws
//
//  channel | dir | payload                                        | handshake
//  req_i   | in  | func, seed_value, range_low, range_high, percent| valid/ready
//  rsp_o   | out | value, hit                                     | valid/ready
//
// reseed gives no word; trivial range/chance: IDLE, then FIN, then the output register
// next word: launch, four multiplier steps, result, output
// range and chance: multiplier, then 32 remainder steps
// one item at a time; req_i.ready is high only while the sequencer is idle
// a finished word waits in the output register while the next request is taken
// reset loads the default seed, no clearing pass
module xorshift_random_source (
  input  logic             clk_i,
  input  logic             rst_ni,
  xrs_req_if.sink          req_i,
  xrs_rsp_if.source        rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                      state_q;
  logic [xrs_pkg::SeedW-1:0]   gen_q;
  xrs_pkg::func_e              op_q;
  logic [xrs_pkg::WordW-1:0]   lo_q;
  logic [xrs_pkg::WordW-1:0]   span_q;
  logic [xrs_pkg::PctW-1:0]    pct_q;
  logic [xrs_pkg::WordW-1:0]   den_q;
  logic [xrs_pkg::WordW-1:0]   res_val_q;
  logic                        res_hit_q;
  logic                        mul_start_q;
  logic                        div_start_q;
  logic                        out_valid_q;
  logic [xrs_pkg::WordW-1:0]   out_val_q;
  logic                        out_hit_q;

  logic [xrs_pkg::SeedW-1:0]   xs_a;
  logic [xrs_pkg::SeedW-1:0]   xs_b;
  logic [xrs_pkg::SeedW-1:0]   xs_next;
  logic [xrs_pkg::WordW-1:0]   span_in;
  logic                        accept;
  xrs_pkg::unit_stat_t         mul_stat;
  xrs_pkg::unit_stat_t         div_stat;
  logic [xrs_pkg::WordW-1:0]   mul_word;
  logic [xrs_pkg::WordW-1:0]   div_rem;

  // state advance: three constant shifts, computed combinationally
  always_comb begin
    xs_a    = gen_q ^ (gen_q >> xrs_pkg::ShA);
    xs_b    = xs_a ^ (xs_a << xrs_pkg::ShB);
    xs_next = xs_b ^ (xs_b >> xrs_pkg::ShC);
    span_in = req_i.range_high - req_i.range_low + 32'd1;
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && (state_q == ST_IDLE);

  xrs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .x_i     (gen_q),
    .stat_o  (mul_stat),
    .word_o  (mul_word)
  );

  xrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (mul_word),
    .divisor_i  (den_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= xrs_pkg::DefaultSeed;
      op_q        <= xrs_pkg::FUNC_NEXT;
      lo_q        <= '0;
      span_q      <= '0;
      pct_q       <= '0;
      den_q       <= '0;
      res_val_q   <= '0;
      res_hit_q   <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_hit_q   <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q      <= req_i.func;
            lo_q      <= req_i.range_low;
            span_q    <= span_in;
            pct_q     <= req_i.percent;
            res_val_q <= '0;
            res_hit_q <= 1'b0;
            unique case (req_i.func)
              xrs_pkg::FUNC_RESEED: begin
                gen_q <= (req_i.seed_value == '0) ? xrs_pkg::DefaultSeed : req_i.seed_value;
              end
              xrs_pkg::FUNC_NEXT: begin
                gen_q       <= xs_next;
                mul_start_q <= 1'b1;
                state_q     <= ST_MUL;
              end
              xrs_pkg::FUNC_RANGE: begin
                if (req_i.range_high <= req_i.range_low) begin
                  res_val_q <= req_i.range_low;
                  state_q   <= ST_FIN;
                end else begin
                  gen_q       <= xs_next;
                  mul_start_q <= 1'b1;
                  state_q     <= ST_MUL;
                end
              end
              xrs_pkg::FUNC_CHANCE: begin
                if (req_i.percent >= xrs_pkg::PctScale[xrs_pkg::PctW-1:0]) begin
                  res_hit_q <= 1'b1;
                  state_q   <= ST_FIN;
                end else if (req_i.percent == '0) begin
                  state_q   <= ST_FIN;
                end else begin
                  gen_q       <= xs_next;
                  mul_start_q <= 1'b1;
                  state_q     <= ST_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            unique case (op_q)
              xrs_pkg::FUNC_RANGE: begin
                // full 32-bit span wraps to zero: raw word, no division
                if (span_q == '0) begin
                  res_val_q <= lo_q + mul_word;
                  state_q   <= ST_FIN;
                end else begin
                  den_q       <= span_q;
                  div_start_q <= 1'b1;
                  state_q     <= ST_DIV;
                end
              end
              xrs_pkg::FUNC_CHANCE: begin
                den_q       <= xrs_pkg::PctScale;
                div_start_q <= 1'b1;
                state_q     <= ST_DIV;
              end
              default: begin
                res_val_q <= mul_word;
                state_q   <= ST_FIN;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (op_q == xrs_pkg::FUNC_CHANCE) begin
              res_hit_q <= (div_rem < {{(xrs_pkg::WordW - xrs_pkg::PctW){1'b0}}, pct_q});
            end else begin
              res_val_q <= lo_q + div_rem;
            end
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          // output register free or being emptied this cycle
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_hit_q   <= res_hit_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.value = out_val_q;
  assign rsp_o.hit   = out_hit_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: checks the xorshift64* random source against a predictor, with stalls on both sides
module tb;

  localparam int unsigned RandomDraws = 1600;
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned SettleWait  = 60;
  localparam int unsigned LongHold    = 400;

  typedef struct {
    xrs_pkg::func_e                func;
    logic [xrs_pkg::SeedW-1:0]     seed;
    logic [xrs_pkg::WordW-1:0]     lo;
    logic [xrs_pkg::WordW-1:0]     hi;
    logic [xrs_pkg::PctW-1:0]      pct;
  } draw_req_t;

  typedef struct {
    logic [xrs_pkg::WordW-1:0] value;
    logic                      hit;
  } draw_word_t;

  // tracks the generator state and the words still owed by the block
  class draw_tracker;
    logic [xrs_pkg::SeedW-1:0] gen_state;
    draw_word_t                pending_draws[$];
    int unsigned               errors;

    function new();
      gen_state = xrs_pkg::DefaultSeed;
      errors    = 0;
    endfunction

    function logic [xrs_pkg::WordW-1:0] step_word();
      logic [xrs_pkg::SeedW-1:0] x;
      logic [xrs_pkg::SeedW-1:0] prod;
      x = gen_state;
      x = x ^ (x >> xrs_pkg::ShA);
      x = x ^ (x << xrs_pkg::ShB);
      x = x ^ (x >> xrs_pkg::ShC);
      gen_state = x;
      prod = x * xrs_pkg::StarMult;
      return prod[xrs_pkg::SeedW-1:xrs_pkg::WordW];
    endfunction

    function void note_request(draw_req_t r);
      draw_word_t                w;
      logic [xrs_pkg::WordW-1:0] span;
      logic [xrs_pkg::WordW-1:0] raw;
      w.value = '0;
      w.hit   = 1'b0;
      case (r.func)
        xrs_pkg::FUNC_RESEED: begin
          gen_state = (r.seed == '0) ? xrs_pkg::DefaultSeed : r.seed;
          return;
        end
        xrs_pkg::FUNC_NEXT: w.value = step_word();
        xrs_pkg::FUNC_RANGE: begin
          if (r.hi <= r.lo) begin
            w.value = r.lo;
          end else begin
            span = r.hi - r.lo + 32'd1;
            raw  = step_word();
            // a span that wraps to zero covers every word, so no reduction
            if (span == '0) w.value = r.lo + raw;
            else            w.value = r.lo + (raw % span);
          end
        end
        xrs_pkg::FUNC_CHANCE: begin
          if (r.pct >= xrs_pkg::PctScale) begin
            w.hit = 1'b1;
          end else if (r.pct != '0) begin
            raw   = step_word();
            w.hit = ((raw % xrs_pkg::PctScale) < r.pct);
          end
        end
        default: ;
      endcase
      pending_draws.insert(pending_draws.size(), w);
    endfunction

    function void check_word(logic [xrs_pkg::WordW-1:0] value, logic hit);
      draw_word_t w;
      if (pending_draws.size() == 0) begin
        $error("unexpected word: value %h hit %b", value, hit);
        errors++;
        return;
      end
      w = pending_draws.pop_front();
      if (value !== w.value) begin
        $error("value: expected %h, got %h", w.value, value);
        errors++;
      end
      if (hit !== w.hit) begin
        $error("hit: expected %b, got %b", w.hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bit          tx_steady;
  int unsigned stuck_cycles;
  draw_tracker board = new();

  xrs_req_if req ();
  xrs_rsp_if rsp ();

  xorshift_random_source dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly back to back, often short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(4, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic draw_req_t random_draw();
    draw_req_t   r;
    int unsigned roll;
    int unsigned shape;
    roll     = $urandom_range(99);
    shape    = $urandom_range(99);
    r.seed   = {$urandom(), $urandom()};
    r.lo     = $urandom();
    r.hi     = $urandom();
    r.pct    = 7'($urandom_range(127));
    if (roll < 30) begin
      r.func = xrs_pkg::FUNC_NEXT;
    end else if (roll < 65) begin
      r.func = xrs_pkg::FUNC_RANGE;
      if (shape < 10) begin
        r.hi = r.lo - $urandom_range(3);
      end else if (shape < 18) begin
        r.lo = '0;
        r.hi = '1;
      end else if (shape < 60) begin
        r.hi = r.lo + $urandom_range(1000, 1);
      end
    end else if (roll < 90) begin
      r.func = xrs_pkg::FUNC_CHANCE;
      if (shape < 10)      r.pct = '0;
      else if (shape < 22) r.pct = 7'($urandom_range(127, 100));
      else                 r.pct = 7'($urandom_range(99, 1));
    end else begin
      r.func = xrs_pkg::FUNC_RESEED;
      if (shape < 15)      r.seed = '0;
      else if (shape < 25) r.seed = {32'd0, $urandom_range(255)};
    end
    return r;
  endfunction

  task automatic offer_draw(input draw_req_t r);
    int unsigned gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid      <= 1'b1;
    req.func       <= r.func;
    req.seed_value <= r.seed;
    req.range_low  <= r.lo;
    req.range_high <= r.hi;
    req.percent    <= r.pct;
    do @(posedge clk); while (!req.ready);
    board.note_request(r);
  endtask

  task automatic offer_fields(input xrs_pkg::func_e f,
                              input logic [xrs_pkg::SeedW-1:0] seed,
                              input logic [xrs_pkg::WordW-1:0] lo,
                              input logic [xrs_pkg::WordW-1:0] hi,
                              input logic [xrs_pkg::PctW-1:0] pct);
    draw_req_t r;
    r.func = f;
    r.seed = seed;
    r.lo   = lo;
    r.hi   = hi;
    r.pct  = pct;
    offer_draw(r);
  endtask

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) board.check_word(rsp.value, rsp.hit);
  end

  always @(posedge clk) begin
    if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : word_sink
    int unsigned words_seen;
    int unsigned idle;
    bit          steady;
    rsp.ready  = 1'b0;
    words_seen = 0;
    steady     = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      words_seen++;
      if (words_seen % 50 == 0) steady = ($urandom_range(3) == 0);
      // one long hold early on so the output register and the input back up
      idle = (words_seen == 40) ? LongHold : pick_gap(steady);
      if (idle > 0) begin
        @(negedge clk);
        rsp.ready <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
    end
  end

  initial begin : draw_source
    clk            = 1'b0;
    rst_n          = 1'b0;
    tx_steady      = 1'b0;
    stuck_cycles   = 0;
    req.valid      = 1'b0;
    req.func       = xrs_pkg::FUNC_NEXT;
    req.seed_value = '0;
    req.range_low  = '0;
    req.range_high = '0;
    req.percent    = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // words straight from the default seed
    offer_fields(xrs_pkg::FUNC_NEXT,   '0, '0, '0, '0);
    offer_fields(xrs_pkg::FUNC_NEXT,   '1, '1, '1, '1);
    // empty, inverted, full and edge ranges
    offer_fields(xrs_pkg::FUNC_RANGE,  '0, 32'd10, 32'd10, '0);
    offer_fields(xrs_pkg::FUNC_RANGE,  '0, 32'd100, 32'd5, '0);
    offer_fields(xrs_pkg::FUNC_RANGE,  '0, '0, '1, '0);
    offer_fields(xrs_pkg::FUNC_RANGE,  '0, 32'hFFFF_FFFE, '1, '0);
    offer_fields(xrs_pkg::FUNC_RANGE,  '0, '0, 32'd1, '0);
    offer_fields(xrs_pkg::FUNC_RANGE,  '0, 32'd7, '1, '0);
    offer_fields(xrs_pkg::FUNC_RANGE,  '1, '1, '0, '1);
    // zero, certain and in-between chances
    offer_fields(xrs_pkg::FUNC_CHANCE, '0, '0, '0, 7'd0);
    offer_fields(xrs_pkg::FUNC_CHANCE, '0, '0, '0, 7'd100);
    offer_fields(xrs_pkg::FUNC_CHANCE, '1, '1, '1, 7'd127);
    offer_fields(xrs_pkg::FUNC_CHANCE, '0, '0, '0, 7'd1);
    offer_fields(xrs_pkg::FUNC_CHANCE, '0, '0, '0, 7'd99);
    offer_fields(xrs_pkg::FUNC_CHANCE, '0, '0, '0, 7'd50);
    // zero seed falls back to the default
    offer_fields(xrs_pkg::FUNC_RESEED, '0, '1, '1, '1);
    offer_fields(xrs_pkg::FUNC_NEXT,   '0, '0, '0, '0);
    offer_fields(xrs_pkg::FUNC_RESEED, '1, '0, '0, '0);
    offer_fields(xrs_pkg::FUNC_NEXT,   '0, '0, '0, '0);
    offer_fields(xrs_pkg::FUNC_RESEED, 64'd1, '0, '0, '0);
    offer_fields(xrs_pkg::FUNC_NEXT,   '0, '0, '0, '0);
    offer_fields(xrs_pkg::FUNC_CHANCE, '0, '0, '0, 7'd64);

    for (int n = 0; n < RandomDraws; n++) begin
      if (n % 64 == 0) tx_steady = ($urandom_range(3) == 0);
      offer_draw(random_draw());
    end
    @(negedge clk);
    req.valid <= 1'b0;

    while (board.pending_draws.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
    if (board.pending_draws.size() != 0) begin
      $error("%0d words never arrived", board.pending_draws.size());
      board.errors++;
    end
    if (board.errors == 0) $display("tb passed");
    else                   $display("tb failed");
    $finish;
  end

endmodule
